/* sv/cas_pkg.sv */
// Shared types and constants for the command line argument splitter.
package cas_pkg;

	// Parsing phases
	localparam logic [1:0] PH_NAME = 2'd0;
	localparam logic [1:0] PH_GAP  = 2'd1;
	localparam logic [1:0] PH_ARG  = 2'd2;

	// Code units with a special meaning
	localparam logic [15:0] U_QUOTE  = 16'h0022;
	localparam logic [15:0] U_BSLASH = 16'h005C;
	localparam logic [15:0] U_SPACE  = 16'h0020;
	localparam logic [15:0] U_TAB    = 16'h0009;
	localparam logic [15:0] U_NUL    = 16'h0000;

	// One result beat, plus a flag telling whether the unit produced one
	typedef struct packed {
		logic        valid;
		logic [7:0]  run;
		logic        has_char;
		logic [15:0] unit;
		logic        eoa;
		logic        eol;
	} cas_res_t;

endpackage

/* sv/cas_step.sv */
// Per-unit split decision with the parser state registers.
module cas_step import cas_pkg::*; #(
	parameter int unsigned MAX_BACKSLASH_RUN = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [15:0] unit,
	output cas_res_t    res
);

	localparam logic [7:0] RUN_LIMIT =
		(MAX_BACKSLASH_RUN > 255) ? 8'd255 : 8'(MAX_BACKSLASH_RUN);

	logic [1:0] phase_q;
	logic       quoted_q;
	logic [7:0] slash_q;
	logic       qpend_q;

	logic [1:0] ph_n;
	logic       q_n;
	logic [7:0] sc_n;
	logic       qp_n;

	logic       is_quote, is_bsl, is_nul, is_blank;

	assign is_quote = (unit == U_QUOTE);
	assign is_bsl   = (unit == U_BSLASH);
	assign is_nul   = (unit == U_NUL);
	assign is_blank = (unit == U_SPACE) || (unit == U_TAB);

	// Next state and result for the unit in the input register
	always_comb begin
		logic       do_arg;
		logic       go_unit;
		logic       a_q;
		logic [7:0] a_sc;
		logic       a_qp;
		logic [7:0] run;
		logic [7:0] base;
		res     = '0;
		ph_n    = phase_q;
		q_n     = quoted_q;
		sc_n    = slash_q;
		qp_n    = qpend_q;
		do_arg  = 1'b0;
		go_unit = 1'b0;
		a_q     = quoted_q;
		a_sc    = slash_q;
		a_qp    = qpend_q;
		run     = '0;
		base    = '0;

		if (phase_q == PH_GAP) begin
			if (is_blank) begin
				// skip separator
			end else if (is_nul) begin
				ph_n    = PH_NAME;
				q_n     = 1'b0;
				sc_n    = '0;
				qp_n    = 1'b0;
				res.eol = 1'b1;
			end else begin
				// new argument starts with this unit
				do_arg = 1'b1;
				ph_n   = PH_ARG;
				a_q    = 1'b0;
				a_sc   = '0;
				a_qp   = 1'b0;
			end
		end else if (phase_q == PH_ARG) begin
			do_arg = 1'b1;
		end else begin
			// program name
			if (is_quote) begin
				q_n = ~quoted_q;
			end else if (is_nul) begin
				ph_n    = PH_NAME;
				q_n     = 1'b0;
				sc_n    = '0;
				qp_n    = 1'b0;
				res.eoa = 1'b1;
				res.eol = 1'b1;
			end else if (!quoted_q && is_blank) begin
				ph_n    = PH_GAP;
				q_n     = 1'b0;
				res.eoa = 1'b1;
			end else begin
				res.has_char = 1'b1;
				res.unit     = unit;
			end
		end

		// Inside an argument
		if (do_arg) begin
			q_n  = a_q;
			sc_n = a_sc;
			qp_n = a_qp;
			if (a_qp) begin
				qp_n = 1'b0;
				sc_n = '0;
				if (is_quote) begin
					// doubled quote inside quotes
					res.run      = a_sc;
					res.has_char = 1'b1;
					res.unit     = U_QUOTE;
				end else begin
					q_n     = 1'b0;
					go_unit = 1'b1;
					run     = a_sc;
				end
			end else if (is_quote) begin
				sc_n = '0;
				if (a_sc[0]) begin
					// odd run: literal quote
					res.run      = {1'b0, a_sc[7:1]};
					res.has_char = 1'b1;
					res.unit     = U_QUOTE;
				end else if (a_q) begin
					// hold the quote for one unit of lookahead
					qp_n = 1'b1;
					sc_n = {1'b0, a_sc[7:1]};
				end else begin
					q_n     = 1'b1;
					res.run = {1'b0, a_sc[7:1]};
				end
			end else if (is_bsl) begin
				go_unit = 1'b1;
				base    = a_sc;
			end else begin
				go_unit = 1'b1;
				run     = a_sc;
			end
		end

		// Plain unit handling, after any held backslashes
		if (go_unit) begin
			res.run = run;
			sc_n    = base;
			if (is_bsl) begin
				sc_n = (base < RUN_LIMIT) ? base + 8'd1 : RUN_LIMIT;
			end else if (is_nul) begin
				ph_n    = PH_NAME;
				q_n     = 1'b0;
				sc_n    = '0;
				qp_n    = 1'b0;
				res.eoa = 1'b1;
				res.eol = 1'b1;
			end else if (!q_n && is_blank) begin
				ph_n    = PH_GAP;
				res.eoa = 1'b1;
			end else begin
				res.has_char = 1'b1;
				res.unit     = unit;
			end
		end

		res.valid = (res.run != 8'd0) || res.has_char || res.eoa || res.eol;
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_NAME;
			quoted_q <= 1'b0;
			slash_q  <= '0;
			qpend_q  <= 1'b0;
		end else if (fire) begin
			phase_q  <= ph_n;
			quoted_q <= q_n;
			slash_q  <= sc_n;
			qpend_q  <= qp_n;
		end
	end

	// A held quote only exists inside a quoted argument
	a_qpend_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		qpend_q |-> (phase_q == PH_ARG) && quoted_q)
		else $error("held quote outside quoted argument");

	// End of line returns the parser to its reset state
	a_eol_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.eol) |=> (phase_q == PH_NAME) && !quoted_q &&
			(slash_q == 8'd0) && !qpend_q)
		else $error("state not cleared after end of line");

	// Backslash count stays within the run limit
	a_run_limit: assert property (@(posedge clk) disable iff (!arst_n)
		slash_q <= RUN_LIMIT)
		else $error("backslash count beyond limit");

endmodule

/* sv/command_line_arg_splitter.sv */
// Top level of the command line argument splitter.
//
// Input channel in_valid/in_ready carries one UTF-16 code unit per beat;
// a zero unit ends the line and the next unit starts a new one.
// Output channel out_valid/out_ready carries one result beat: a count of
// backslashes, an optional character, and end of argument / end of line
// marks. Units that only skip blanks, open quoting or are held for
// lookahead produce no beat.
// A unit is captured in an input register and decided from there into the
// output register; out_valid rises when that register loads a result.
// Throughput is one unit per cycle while the receiver takes results; the
// state update of the per-unit decision is the only loop.
// When the receiver stalls with a result waiting, one more unit is held
// in the input register; further units wait until out_ready returns,
// except that units producing no beat still drain.
// Reset (arst_n low) empties both registers and puts the parser in the
// program name phase with no quoting and no backslashes counted.
module command_line_arg_splitter import cas_pkg::*; #(
	parameter int unsigned MAX_BACKSLASH_RUN = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] code_unit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  backslash_run,
	output logic        has_char,
	output logic [15:0] out_unit,
	output logic        end_of_argument,
	output logic        end_of_line
);

	logic        valid_s1;
	logic [15:0] unit_s1;
	cas_res_t    res;
	logic        fire;
	logic        load;
	logic        slot_free;

	// Decide the held unit when its result, if any, has a place to go
	assign slot_free = !out_valid || out_ready;
	assign fire      = valid_s1 && (!res.valid || slot_free);
	assign load      = fire && res.valid;
	assign in_ready  = !valid_s1 || fire;

	cas_step #(
		.MAX_BACKSLASH_RUN(MAX_BACKSLASH_RUN)
	) u_step (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.unit  (unit_s1),
		.res   (res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			unit_s1 <= code_unit;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			backslash_run   <= res.run;
			has_char        <= res.has_char;
			out_unit        <= res.unit;
			end_of_argument <= res.eoa;
			end_of_line     <= res.eol;
		end
	end

	// A delivered beat always carries something
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (backslash_run != 8'd0) || has_char ||
			end_of_argument || end_of_line)
		else $error("empty result beat");

	// No character means a zero unit field
	a_unit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_char) |-> (out_unit == 16'd0))
		else $error("unit set without character");

	// A result is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> slot_free)
		else $error("result register overwritten");

endmodule

/* tb/cas_checker.sv */
// Watches both channels of the argument splitter, predicts each result beat and compares.
`timescale 1ns / 1ps

module cas_checker import cas_pkg::*; #(
	parameter int unsigned MAX_BACKSLASH_RUN = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [15:0] code_unit,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  backslash_run,
	input  logic        has_char,
	input  logic [15:0] out_unit,
	input  logic        end_of_argument,
	input  logic        end_of_line,
	output int          mismatches,
	output int          beats_owed
);

	// backslash counter saturates at the smaller of the parameter and 8 bits
	localparam logic [7:0] RUN_CAP =
		(MAX_BACKSLASH_RUN > 255) ? 8'd255 : 8'(MAX_BACKSLASH_RUN);

	// predicted parser state
	logic [1:0] cur_phase;
	logic       in_quotes;
	logic [7:0] slash_cnt;
	logic       quote_held;

	cas_res_t expected_beats[$];
	int       beat_no;

	function automatic cas_res_t make_beat(logic [7:0] run, logic ch, logic [15:0] unit,
			logic eoa, logic eol);
		cas_res_t b;
		b.valid    = (run != 8'd0) || ch || eoa || eol;
		b.run      = run;
		b.has_char = ch;
		b.unit     = ch ? unit : 16'h0000;
		b.eoa      = eoa;
		b.eol      = eol;
		return b;
	endfunction

	task automatic clear_state();
		cur_phase  = PH_NAME;
		in_quotes  = 1'b0;
		slash_cnt  = 8'd0;
		quote_held = 1'b0;
	endtask

	// unit inside an argument with no quote held; run = backslashes still to emit
	task automatic arg_step(input logic [15:0] u, input logic [7:0] run, output cas_res_t r);
		if (u == U_BSLASH) begin
			slash_cnt = (slash_cnt < RUN_CAP) ? slash_cnt + 8'd1 : RUN_CAP;
			r = make_beat(run, 1'b0, 16'h0000, 1'b0, 1'b0);
		end else if (u == U_NUL) begin
			clear_state();
			r = make_beat(run, 1'b0, 16'h0000, 1'b1, 1'b1);
		end else if (!in_quotes && (u == U_SPACE || u == U_TAB)) begin
			cur_phase = PH_GAP;
			r = make_beat(run, 1'b0, 16'h0000, 1'b1, 1'b0);
		end else begin
			r = make_beat(run, 1'b1, u, 1'b0, 1'b0);
		end
	endtask

	// next state and the beat (if any) caused by one accepted unit
	task automatic parse_unit(input logic [15:0] u, output cas_res_t r);
		logic [7:0] run;
		logic [7:0] n;
		logic       blank;
		blank = (u == U_SPACE) || (u == U_TAB);
		r = '0;
		if (cur_phase == PH_GAP) begin
			if (blank)
				return;
			if (u == U_NUL) begin
				clear_state();
				r = make_beat(8'd0, 1'b0, 16'h0000, 1'b0, 1'b1);
				return;
			end
			cur_phase  = PH_ARG;
			in_quotes  = 1'b0;
			slash_cnt  = 8'd0;
			quote_held = 1'b0;
		end
		if (cur_phase == PH_ARG) begin
			// a quote seen inside quotes waits for the next unit
			if (quote_held) begin
				run = slash_cnt;
				quote_held = 1'b0;
				slash_cnt = 8'd0;
				if (u == U_QUOTE) begin
					r = make_beat(run, 1'b1, U_QUOTE, 1'b0, 1'b0);
					return;
				end
				in_quotes = 1'b0;
				arg_step(u, run, r);
				return;
			end
			if (u == U_QUOTE) begin
				n = slash_cnt;
				slash_cnt = 8'd0;
				if (n[0]) begin
					r = make_beat(n >> 1, 1'b1, U_QUOTE, 1'b0, 1'b0);
				end else if (in_quotes) begin
					quote_held = 1'b1;
					slash_cnt = n >> 1;
				end else begin
					in_quotes = 1'b1;
					r = make_beat(n >> 1, 1'b0, 16'h0000, 1'b0, 1'b0);
				end
				return;
			end
			if (u == U_BSLASH) begin
				run = 8'd0;
			end else begin
				run = slash_cnt;
				slash_cnt = 8'd0;
			end
			arg_step(u, run, r);
			return;
		end
		// program name (phase 3 lands here too)
		if (u == U_QUOTE) begin
			in_quotes = !in_quotes;
		end else if (u == U_NUL) begin
			clear_state();
			r = make_beat(8'd0, 1'b0, 16'h0000, 1'b1, 1'b1);
		end else if (!in_quotes && blank) begin
			cur_phase = PH_GAP;
			in_quotes = 1'b0;
			r = make_beat(8'd0, 1'b0, 16'h0000, 1'b1, 1'b0);
		end else begin
			r = make_beat(8'd0, 1'b1, u, 1'b0, 1'b0);
		end
	endtask

	task automatic report(input string what, input int got, input int want);
		if (mismatches < 100)
			$display("MISMATCH t=%0t beat %0d: %s got %0h expected %0h",
				$time, beat_no, what, got, want);
		mismatches++;
	endtask

	// output beats are checked before the same edge's input is predicted
	always @(posedge clk or negedge arst_n) begin : watch
		cas_res_t want;
		cas_res_t fresh;
		if (!arst_n) begin
			clear_state();
			expected_beats.delete();
			mismatches = 0;
			beats_owed = 0;
			beat_no = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_beats.size() == 0) begin
					report("unexpected beat, out_unit", out_unit, 0);
				end else begin
					want = expected_beats.pop_front();
					if (backslash_run !== want.run)
						report("backslash_run", backslash_run, want.run);
					if (has_char !== want.has_char)
						report("has_char", has_char, want.has_char);
					if (out_unit !== want.unit)
						report("out_unit", out_unit, want.unit);
					if (end_of_argument !== want.eoa)
						report("end_of_argument", end_of_argument, want.eoa);
					if (end_of_line !== want.eol)
						report("end_of_line", end_of_line, want.eol);
				end
				beat_no++;
			end
			if (in_valid && in_ready) begin
				parse_unit(code_unit, fresh);
				if (fresh.valid)
					expected_beats.insert(expected_beats.size(), fresh);
			end
			beats_owed = expected_beats.size();
		end
	end

endmodule

/* tb/tb_command_line_arg_splitter.sv */
// Testbench top for the argument splitter: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_command_line_arg_splitter import cas_pkg::*;;

	localparam int RANDOM_UNITS = 1900;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] code_unit = 16'h0000;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  backslash_run;
	logic        has_char;
	logic [15:0] out_unit;
	logic        end_of_argument;
	logic        end_of_line;

	int mismatches;
	int beats_owed;
	int units_sent = 0;

	command_line_arg_splitter uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.code_unit      (code_unit),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.backslash_run  (backslash_run),
		.has_char       (has_char),
		.out_unit       (out_unit),
		.end_of_argument(end_of_argument),
		.end_of_line    (end_of_line)
	);

	cas_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.code_unit      (code_unit),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.backslash_run  (backslash_run),
		.has_char       (has_char),
		.out_unit       (out_unit),
		.end_of_argument(end_of_argument),
		.end_of_line    (end_of_line),
		.mismatches     (mismatches),
		.beats_owed     (beats_owed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop
	initial begin
		#2_000_000;
		$display("** command_line_arg_splitter: FAILED **");
		$finish;
	end

	// hold valid until the beat is taken
	task automatic send_unit(input logic [15:0] u);
		in_valid  <= 1'b1;
		code_unit <= u;
		do @(posedge clk); while (!in_ready);
		units_sent++;
	endtask

	// receiver: changing stall patterns, plus one long hold-off while the sender keeps going
	initial begin
		int  mode;
		int  span;
		int  cyc;
		bit  held_off;
		held_off = 1'b0;
		cyc = 0;
		wait (arst_n === 1'b1);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			repeat (span) begin
				@(posedge clk);
				cyc++;
				if (!held_off && units_sent >= 600) begin
					held_off = 1'b1;
					out_ready <= 1'b0;
					repeat (300) @(posedge clk);
				end
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 0);
					2: out_ready <= ($urandom_range(0, 4) == 0);
					default: out_ready <= (cyc % 3 == 0);
				endcase
			end
		end
	end

	// stimulus
	initial begin
		logic [15:0] stim[$];
		logic [15:0] u;
		int          n_directed;
		int          len;
		int          pick;
		int          burst;
		int          gap;
		int          drain;

		// quoted program name, blanks, even and odd backslash runs before quotes,
		// doubled quote, held quote then blank, zero between and inside arguments
		stim = '{U_NUL,
			U_QUOTE, 16'h006E, U_SPACE, U_QUOTE, U_TAB,
			U_BSLASH, U_BSLASH, U_QUOTE, 16'h0061, U_QUOTE, U_QUOTE, 16'h0062, U_QUOTE,
			U_SPACE, U_BSLASH, U_BSLASH, U_BSLASH, U_QUOTE, 16'hFFFF, U_SPACE, U_NUL,
			16'h0078, U_SPACE, U_QUOTE, 16'h0071, U_NUL};
		n_directed = stim.size();

		// random lines, mostly text with quoting and backslashes, now and then a long run
		while (stim.size() < n_directed + RANDOM_UNITS) begin
			len = $urandom_range(0, 24);
			for (int k = 0; k < len; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 35)      u = 16'h0061 + 16'($urandom_range(0, 25));
				else if (pick < 47) u = U_SPACE;
				else if (pick < 52) u = U_TAB;
				else if (pick < 67) u = U_QUOTE;
				else if (pick < 84) u = U_BSLASH;
				else if (pick < 92) u = 16'($urandom);
				else                u = 16'($urandom_range(1, 127));
				stim.insert(stim.size(), u);
			end
			if ($urandom_range(0, 59) == 0) begin
				repeat ($urandom_range(250, 270)) stim.insert(stim.size(), U_BSLASH);
				stim.insert(stim.size(), $urandom_range(0, 1) ? U_QUOTE : 16'h007A);
			end
			stim.insert(stim.size(), U_NUL);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bursts of random length separated by random gaps
		burst = $urandom_range(1, 40);
		foreach (stim[i]) begin
			send_unit(stim[i]);
			burst--;
			if (burst == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst = $urandom_range(1, 40);
			end
		end
		in_valid <= 1'b0;

		drain = 0;
		while (beats_owed != 0 && drain < 5000) begin
			@(negedge clk);
			drain++;
		end
		repeat (16) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && beats_owed == 0)
			$display("** command_line_arg_splitter: PASSED **");
		else
			$display("** command_line_arg_splitter: FAILED **");
		$finish;
	end

endmodule
